>>> hdl/tsa_pkg.sv
// Package for the triangle strip assembler: vertex and item types, restart code.
// No dependencies; every other file of the block imports it.
package tsa_pkg;

  localparam int unsigned VERTEX_W = 16;

  typedef logic [VERTEX_W-1:0] vertex_t;

  localparam vertex_t RESTART_INDEX = 16'hFFFF;

  typedef struct packed {
    vertex_t vertex_index;
    logic    end_of_strip;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } stage_t;

  typedef struct packed {
    vertex_t first_vertex;
    vertex_t second_vertex;
    vertex_t third_vertex;
  } tri_t;

endpackage

>>> hdl/tsa_if.sv
// Channel interfaces of the triangle strip assembler: index input, triangle output
// and the mode configuration write. Depends on tsa_pkg.
interface tsa_in_if
  import tsa_pkg::*;
();
  logic    valid;
  logic    ready;
  vertex_t vertex_index;
  logic    end_of_strip;

  modport source (output valid, output vertex_index, output end_of_strip, input ready);
  modport sink   (input valid, input vertex_index, input end_of_strip, output ready);
endinterface

interface tsa_out_if
  import tsa_pkg::*;
();
  logic    valid;
  logic    ready;
  vertex_t first_vertex;
  vertex_t second_vertex;
  vertex_t third_vertex;

  modport source (output valid, output first_vertex, output second_vertex,
                  output third_vertex, input ready);
  modport sink   (input valid, input first_vertex, input second_vertex,
                  input third_vertex, output ready);
endinterface

interface tsa_cfg_if ();
  logic valid;
  logic ready;
  logic list_mode;

  modport source (output valid, output list_mode, input ready);
  modport sink   (input valid, input list_mode, output ready);
endinterface

>>> hdl/tsa_input_stage.sv
// Input register of the triangle strip assembler: holds one index item per transfer.
// Depends on tsa_pkg.
module tsa_input_stage
  import tsa_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_ready,
  input  item_t  in_item,
  output stage_t stage_o,
  input  logic   stage_take
);

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;

  assign in_ready  = !valid_r || stage_take;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign stage_o = '{valid: valid_r, item: item_r};

endmodule

>>> hdl/tsa_assembly.sv
// Assembly stage: held vertices, winding and culling, and the triangle output register.
// Depends on tsa_pkg.
module tsa_assembly
  import tsa_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   list_mode,
  input  stage_t stage_i,
  output logic   stage_take,
  output logic   out_valid,
  input  logic   out_ready,
  output tri_t   out_tri
);

  vertex_t    older_r, older_nxt;
  vertex_t    newer_r, newer_nxt;
  logic [1:0] held_r, held_nxt;
  logic       odd_r, odd_nxt;
  logic       out_valid_r, out_valid_nxt;
  tri_t       tri_r, tri_nxt;
  logic       emit;
  logic       full;
  vertex_t    c;

  assign c    = stage_i.item.vertex_index;
  assign full = held_r[1];

  always_comb begin
    older_nxt = older_r;
    newer_nxt = newer_r;
    held_nxt  = held_r;
    odd_nxt   = odd_r;
    emit      = 1'b0;
    tri_nxt   = '{first_vertex: older_r, second_vertex: newer_r, third_vertex: c};
    if (list_mode) begin
      if (full) begin
        emit      = 1'b1;
        older_nxt = '0;
        newer_nxt = '0;
        held_nxt  = 2'd0;
      end else begin
        older_nxt = newer_r;
        newer_nxt = c;
        held_nxt  = held_r + 2'd1;
      end
    end else if (c == RESTART_INDEX) begin
      older_nxt = '0;
      newer_nxt = '0;
      held_nxt  = 2'd0;
      odd_nxt   = 1'b0;
    end else begin
      older_nxt = newer_r;
      newer_nxt = c;
      if (full) begin
        emit    = (older_r != newer_r) && (newer_r != c) && (c != older_r);
        odd_nxt = !odd_r;
        if (odd_r) begin
          tri_nxt.first_vertex  = newer_r;
          tri_nxt.second_vertex = older_r;
        end
      end else begin
        held_nxt = held_r + 2'd1;
      end
    end
    if (stage_i.item.end_of_strip) begin
      older_nxt = '0;
      newer_nxt = '0;
      held_nxt  = 2'd0;
      odd_nxt   = 1'b0;
    end
  end

  assign stage_take = stage_i.valid && (!out_valid_r || out_ready || !emit);

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    if (stage_take && emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      older_r     <= '0;
      newer_r     <= '0;
      held_r      <= 2'd0;
      odd_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (stage_take) begin
        older_r <= older_nxt;
        newer_r <= newer_nxt;
        held_r  <= held_nxt;
        odd_r   <= odd_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stage_take && emit) begin
      tri_r <= tri_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_tri   = tri_r;

endmodule

>>> hdl/triangle_strip_assembler.sv
// Triangle strip assembler: one index per transfer, at most one triangle out.
// An index is registered in the input stage, and its triangle in the assembly output register;
// one index is taken every cycle unless a waiting triangle blocks an index that emits one, and a
// waiting triangle does not block indices that emit nothing. Synchronous active-low reset
// clears the held vertices, winding, list mode and all valid flags. Depends on tsa_pkg.
module triangle_strip_assembler
  import tsa_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  tsa_in_if.sink    in_chan,
  tsa_out_if.source out_chan,
  tsa_cfg_if.sink   cfg_chan
);

  logic   list_mode_r;
  stage_t stage;
  logic   stage_take;
  tri_t   tri_q;
  logic   in_ready;
  item_t  in_item;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      list_mode_r <= 1'b0;
    end else if (cfg_chan.valid) begin
      list_mode_r <= cfg_chan.list_mode;
    end
  end

  assign in_item = '{vertex_index: in_chan.vertex_index, end_of_strip: in_chan.end_of_strip};
  assign in_chan.ready = in_ready;

  tsa_input_stage u_input (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .stage_o   (stage),
    .stage_take(stage_take)
  );

  tsa_assembly u_assembly (
    .clk       (clk),
    .rst_n     (rst_n),
    .list_mode (list_mode_r),
    .stage_i   (stage),
    .stage_take(stage_take),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_tri   (tri_q)
  );

  assign out_chan.first_vertex  = tri_q.first_vertex;
  assign out_chan.second_vertex = tri_q.second_vertex;
  assign out_chan.third_vertex  = tri_q.third_vertex;

endmodule

>>> dv/triangle_strip_assembler_tb.sv
// Self-checking testbench for the triangle strip assembler: directed and random index streams
// in strip and list mode, with random stalls on both channels and a long output hold-off.
// Depends on tsa_pkg, the channel interfaces and the triangle_strip_assembler RTL.
module triangle_strip_assembler_tb;
  import tsa_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  class triangle_scoreboard;
    bit        list_mode;
    vertex_t   older_vertex;
    vertex_t   newer_vertex;
    bit [1:0]  held_count;
    bit        odd_winding;
    tri_t      pending_tris[$];
    int        mismatches;

    function new();
      list_mode  = 1'b0;
      mismatches = 0;
      clear_strip();
    endfunction

    function void clear_strip();
      older_vertex = '0;
      newer_vertex = '0;
      held_count   = '0;
      odd_winding  = 1'b0;
    endfunction

    function void hold_vertex(vertex_t v);
      older_vertex = newer_vertex;
      newer_vertex = v;
      if (held_count < 2) held_count++;
    endfunction

    function void note_index(vertex_t v, logic eos);
      tri_t t;
      if (list_mode) begin
        if (held_count >= 2) begin
          t = '{older_vertex, newer_vertex, v};
          pending_tris.insert(pending_tris.size(), t);
          older_vertex = '0;
          newer_vertex = '0;
          held_count   = '0;
        end else begin
          hold_vertex(v);
        end
      end else if (v == RESTART_INDEX) begin
        clear_strip();
      end else if (held_count >= 2) begin
        if (older_vertex != newer_vertex && newer_vertex != v && v != older_vertex) begin
          t.first_vertex  = odd_winding ? newer_vertex : older_vertex;
          t.second_vertex = odd_winding ? older_vertex : newer_vertex;
          t.third_vertex  = v;
          pending_tris.insert(pending_tris.size(), t);
        end
        hold_vertex(v);
        odd_winding = ~odd_winding;
      end else begin
        hold_vertex(v);
      end
      if (eos) clear_strip();
    endfunction

    function void report_mismatch(string msg);
      mismatches++;
      if (mismatches <= 10) $display("mismatch: %s", msg);
    endfunction

    function void check_triangle(tri_t got);
      tri_t exp;
      if (pending_tris.size() == 0) begin
        report_mismatch($sformatf("unexpected triangle %h %h %h",
                                  got.first_vertex, got.second_vertex, got.third_vertex));
        return;
      end
      exp = pending_tris.pop_front();
      if (got.first_vertex !== exp.first_vertex || got.second_vertex !== exp.second_vertex ||
          got.third_vertex !== exp.third_vertex) begin
        report_mismatch($sformatf("expected %h %h %h, got %h %h %h",
                                  exp.first_vertex, exp.second_vertex, exp.third_vertex,
                                  got.first_vertex, got.second_vertex, got.third_vertex));
      end
    endfunction

    function int pending();
      return pending_tris.size();
    endfunction
  endclass

  localparam logic [16:0] DIRECTED_STRIP [16] = '{
    17'h00000, 17'h00001, 17'h00002, 17'h00003, 17'h00003, 17'h00004, 17'h0FFFE,
    17'h0FFFF, 17'h00005, 17'h0FFFF, 17'h0FFFF, 17'h00006, 17'h00007, 17'h00008,
    17'h00009, 17'h1000A
  };
  localparam logic [16:0] DIRECTED_LIST [11] = '{
    17'h0000B, 17'h0000C, 17'h0000D,
    17'h0FFFF, 17'h00000, 17'h0FFFE, 17'h00001, 17'h10002, 17'h00003, 17'h00004, 17'h00005
  };

  logic clk;
  logic rst_n;
  bit   stall_enable;
  bit   hold_request;

  triangle_scoreboard sb;

  tsa_in_if  in_chan ();
  tsa_out_if out_chan ();
  tsa_cfg_if cfg_chan ();

  triangle_strip_assembler i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  initial begin
    clk = 1'b0;
  end

  always #2 clk = ~clk;

  initial begin
    #2ms;
    $display("triangle_strip_assembler_tb: errors");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_chan.valid && in_chan.ready) sb.note_index(in_chan.vertex_index, in_chan.end_of_strip);
      if (out_chan.valid && out_chan.ready) begin
        sb.check_triangle('{out_chan.first_vertex, out_chan.second_vertex, out_chan.third_vertex});
      end
    end
  end

  initial begin
    out_chan.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_chan.ready <= 1'b0;
        repeat (300) @(negedge clk);
      end else if (stall_enable && $urandom_range(0, 2) == 0) begin
        out_chan.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end else begin
        out_chan.ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
    end
  end

  task automatic send_index(vertex_t v, logic eos);
    if (stall_enable && $urandom_range(0, 3) == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_chan.valid        <= 1'b1;
    in_chan.vertex_index <= v;
    in_chan.end_of_strip <= eos;
    do @(posedge clk); while (!in_chan.ready);
    @(negedge clk);
  endtask

  task automatic write_list_mode(bit mode);
    while (sb.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    @(negedge clk);
    cfg_chan.valid     <= 1'b1;
    cfg_chan.list_mode <= mode;
    do @(posedge clk); while (!cfg_chan.ready);
    sb.list_mode = mode;
    @(negedge clk);
    cfg_chan.valid <= 1'b0;
  endtask

  function automatic vertex_t pick_index(vertex_t base);
    case ($urandom_range(0, 9))
      0:       return RESTART_INDEX;
      1, 2:    return vertex_t'($urandom);
      default: return base + vertex_t'($urandom_range(0, 3));
    endcase
  endfunction

  initial begin
    vertex_t base;
    int      count;
    sb = new();
    stall_enable = 1'b1;
    hold_request = 1'b0;
    in_chan.valid        = 1'b0;
    in_chan.vertex_index = '0;
    in_chan.end_of_strip = 1'b0;
    cfg_chan.valid       = 1'b0;
    cfg_chan.list_mode   = 1'b0;
    rst_n = 1'b0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    write_list_mode(1'b0);
    foreach (DIRECTED_STRIP[i]) send_index(DIRECTED_STRIP[i][15:0], DIRECTED_STRIP[i][16]);
    in_chan.valid <= 1'b0;
    write_list_mode(1'b1);
    foreach (DIRECTED_LIST[i]) send_index(DIRECTED_LIST[i][15:0], DIRECTED_LIST[i][16]);
    in_chan.valid <= 1'b0;

    for (int p = 0; p < 14; p++) begin
      if (p == 12) stall_enable = 1'b0;
      write_list_mode(p == 0 ? 1'b0 : (p == 1 ? 1'b1 : bit'($urandom_range(0, 1))));
      if (p == 5) hold_request = 1'b1;
      base  = vertex_t'($urandom);
      count = $urandom_range(48, 80);
      for (int i = 0; i < count; i++) begin
        if ($urandom_range(0, 15) == 0) base = vertex_t'($urandom);
        send_index(pick_index(base), $urandom_range(0, 24) == 0);
      end
      in_chan.valid <= 1'b0;
    end

    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("triangle_strip_assembler_tb: clean");
    end else begin
      $display("triangle_strip_assembler_tb: errors");
    end
    $finish;
  end

endmodule
